// ----- rtl/core/ltp3_pkg.sv -----
package ltp3_pkg;

	// Width of one raw depth sample.
	localparam int DEPTH_W = 16;

	// Width of the geometry registers and the threshold register.
	localparam int DIM_W = 13;
	localparam int THR_W = 16;

	// Width of the reported center coordinates.
	localparam int COORD_W = 12;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_K  = 2'd2;

	// Reset values of the configuration registers.
	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;
	localparam logic [THR_W-1:0] THR_RESET = 16'd3;

	// Smallest legal frame dimension.
	localparam int DIM_MIN = 3;

	// Depth of the result queue that decouples the output from the pipeline.
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = 2;
	localparam int OUT_CNT_W = 3;

	// Code bit of each window position, rows top to bottom, columns left to right.
	// E=0, NE=1, N=2, NW=3, W=4, SW=5, S=6, SE=7; the center carries no bit.
	typedef logic [2:0] bit_sel_t;
	localparam bit_sel_t BIT_OF_POS [3][3] = '{
		'{3'd3, 3'd2, 3'd1},
		'{3'd4, 3'd0, 3'd0},
		'{3'd5, 3'd6, 3'd7}
	};

	// One entry of the line memory: the column's samples from the two previous rows.
	typedef struct packed {
		logic [DEPTH_W-1:0] upper;
		logic [DEPTH_W-1:0] middle;
	} line_pair_t;

	// One result item.
	typedef struct packed {
		logic               frame_done;
		logic [COORD_W-1:0] center_row;
		logic [COORD_W-1:0] center_col;
		logic [7:0]         neg_code;
		logic [7:0]         pos_code;
	} ltp_result_t;

endpackage

// ----- rtl/core/local_ternary_pattern_3x3.sv -----
// Channel   Direction  Beat contents
// s_axis    in         tdata[15:0] depth_sample, one pixel in raster order
// m_axis    out        tdata[7:0] pos_code, [15:8] neg_code, [27:16] center_col,
//                      [39:28] center_row; tlast frame_done
// cfg       in         cfg_we, cfg_index, cfg_data; write only, no wait
//
// One pixel per clock is accepted while s_axis tready is high.
// The single line memory takes one read and one write per pixel.
// Reset clears the counters, the pipeline and the result queue; the line memory
// and the window hold no reset; a result uses only samples written in its frame.
// A four-entry result queue takes results while m_axis stalls; s_axis tready drops
// only when the queue plus the pixels in flight could overflow it.
module local_ternary_pattern_3x3 #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Input stream.
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [ltp3_pkg::DEPTH_W-1:0]         s_axis_tdata,  // [15:0] depth_sample
	// Output stream.
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [39:0]                          m_axis_tdata,  // [7:0] pos_code,
	                                                            // [15:8] neg_code,
	                                                            // [27:16] center_col,
	                                                            // [39:28] center_row
	output logic                                 m_axis_tlast,  // frame_done
	// Configuration writes.
	input  logic                                 cfg_we,
	input  logic [ltp3_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ltp3_pkg::CFG_DATA_W-1:0]      cfg_data
);

	import ltp3_pkg::*;

	localparam int CB = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int RB = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
	localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
	localparam int H_RST = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;
	localparam logic [31:0] MAXW32 = 32'(MAX_WIDTH);
	localparam logic [31:0] MAXH32 = 32'(MAX_HEIGHT);
	localparam logic [31:0] MIN32  = 32'(DIM_MIN);

	// Configuration: last column and last row after clamping, and the threshold.
	logic [CB-1:0]    wlast_q;
	logic [RB-1:0]    hlast_q;
	logic [THR_W-1:0] thr_q;
	logic [31:0]      dim_raw;
	logic [31:0]      wclamp;
	logic [31:0]      hclamp;
	logic             geom_wr;

	// Raster position of the next pixel.
	logic [CB-1:0] col_q;
	logic [RB-1:0] row_q;

	// Stage 1: line memory read data arrives.
	logic                 valid_s1;
	logic                 interior_s1;
	logic                 done_s1;
	logic [CB-1:0]        col_s1;
	logic [RB-1:0]        row_s1;
	logic [DEPTH_W-1:0]   depth_s1;

	// Stage 2: window holds the neighborhood of the result's center.
	logic                 valid_s2;
	logic                 done_s2;
	logic [COORD_W-1:0]   ccol_s2;
	logic [COORD_W-1:0]   crow_s2;

	// Line memory.
	line_pair_t           line_mem [MAX_WIDTH];
	line_pair_t           rd_pair_q;

	// 3x3 window, rows top to bottom, columns left to right.
	logic [DEPTH_W-1:0]   win_q [3][3];

	// Result queue.
	ltp_result_t          fifo_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [OUT_CNT_W-1:0] fifo_cnt_q;
	logic [OUT_CNT_W-1:0] in_flight;

	logic                 accept;
	logic                 push;
	logic                 pop;
	logic                 col_last;
	logic                 row_last;
	logic [CB-1:0]        col_m1;
	logic [RB-1:0]        row_m1;
	ltp_result_t          result;

	// Geometry clamp for a configuration write.
	always_comb begin
		dim_raw = 32'(cfg_data[DIM_W-1:0]);
		if (dim_raw < MIN32) begin
			wclamp = MIN32;
			hclamp = MIN32;
		end else begin
			wclamp = (dim_raw > MAXW32) ? MAXW32 : dim_raw;
			hclamp = (dim_raw > MAXH32) ? MAXH32 : dim_raw;
		end
		geom_wr = cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q <= CB'(W_RST - 1);
			hlast_q <= RB'(H_RST - 1);
			thr_q   <= THR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  wlast_q <= CB'(wclamp - 32'd1);
				REG_FRAME_HEIGHT: hlast_q <= RB'(hclamp - 32'd1);
				REG_THRESHOLD_K:  thr_q   <= cfg_data[THR_W-1:0];
				default:          ;
			endcase
		end
	end

	// Flow control: every pixel in flight may still need a queue slot.
	assign in_flight     = fifo_cnt_q + OUT_CNT_W'(valid_s1) + OUT_CNT_W'(valid_s2);
	assign s_axis_tready = (in_flight < OUT_CNT_W'(OUT_DEPTH));
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign col_last = (col_q == wlast_q);
	assign row_last = (row_q == hlast_q);

	// Raster counters; a geometry write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (geom_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Line memory: read at the pixel's column on accept, write back in the cycle after.
	// The same column comes round again only after at least three pixels, so the
	// write has always landed before the next read of that entry.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			line_mem[col_s1] <= '{upper: rd_pair_q.middle, middle: depth_s1};
		end
		if (accept) begin
			rd_pair_q <= line_mem[col_q];
		end
	end

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1      <= col_q;
			row_s1      <= row_q;
			depth_s1    <= s_axis_tdata;
			interior_s1 <= (col_q >= CB'(2)) && (row_q >= RB'(2));
			done_s1     <= col_last && row_last;
		end
	end

	// Window shift: the new right column comes from the memory and the pixel.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			for (int y = 0; y < 3; y++) begin
				win_q[y][0] <= win_q[y][1];
				win_q[y][1] <= win_q[y][2];
			end
			win_q[0][2] <= rd_pair_q.upper;
			win_q[1][2] <= rd_pair_q.middle;
			win_q[2][2] <= depth_s1;
		end
	end

	assign col_m1 = col_s1 - 1'b1;
	assign row_m1 = row_s1 - 1'b1;

	// Stage 2 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1 && interior_s1;
		end
	end

	// Stage 2 payload.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			ccol_s2 <= COORD_W'(col_m1);
			crow_s2 <= COORD_W'(row_m1);
			done_s2 <= done_s1;
		end
	end

	// Ternary compares of the eight neighbors against the center, widened by one bit.
	always_comb begin
		logic [DEPTH_W:0] ctr;
		logic [DEPTH_W:0] k;
		logic [DEPTH_W:0] v;
		ctr = {1'b0, win_q[1][1]};
		k   = {1'b0, thr_q};
		result = '0;
		for (int y = 0; y < 3; y++) begin
			for (int x = 0; x < 3; x++) begin
				v = {1'b0, win_q[y][x]};
				if (!(y == 1 && x == 1)) begin
					result.pos_code[BIT_OF_POS[y][x]] = (v > ctr + k);
					result.neg_code[BIT_OF_POS[y][x]] = (v + k < ctr);
				end
			end
		end
		result.center_col = ccol_s2;
		result.center_row = crow_s2;
		result.frame_done = done_s2;
	end

	assign push = valid_s2;
	assign pop  = m_axis_tvalid && m_axis_tready;

	// Result queue pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fifo_cnt_q <= fifo_cnt_q + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
		end
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= result;
		end
	end

	// Output beat.
	assign m_axis_tvalid = (fifo_cnt_q != '0);
	assign m_axis_tdata  = {fifo_q[rd_ptr_q].center_row, fifo_q[rd_ptr_q].center_col,
	                        fifo_q[rd_ptr_q].neg_code, fifo_q[rd_ptr_q].pos_code};
	assign m_axis_tlast  = fifo_q[rd_ptr_q].frame_done;

`ifndef SYNTHESIS
	// The queue never holds more than its depth.
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= OUT_CNT_W'(OUT_DEPTH))
		else $error("result queue count out of range");

	// A push never finds the queue full unless a beat leaves in the same cycle.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (fifo_cnt_q < OUT_CNT_W'(OUT_DEPTH)) || pop)
		else $error("result pushed into a full queue");

	// The raster counters stay inside the configured frame.
	a_counter_range: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= wlast_q) && (row_q <= hlast_q))
		else $error("raster counter beyond frame");

	// A result in stage 2 comes from an interior pixel in stage 1 in the cycle before.
	a_s2_origin: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $past(valid_s1 && interior_s1))
		else $error("stage 2 result without interior pixel");

	// Each accepted pixel is in stage 1 in the cycle after.
	a_s1_origin: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted pixel missing from stage 1");
`endif

endmodule

// ----- verif/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ltp3_pkg::*;

	localparam int MAX_DIM = 4096;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int WIDE_PIXELS = 40;
	localparam int TALL_ROWS = 40;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// How the pixel values of one stretch of stimulus are drawn.
	typedef enum int {
		PIX_NOISE,
		PIX_NEAR_THRESHOLD,
		PIX_EXTREME,
		PIX_PLATEAU
	} pix_mode_e;

	logic clk;
	logic arst_n = 1'b0;

	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [DEPTH_W-1:0]    s_axis_tdata = '0;  // [15:0] depth_sample
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [39:0]           m_axis_tdata;       // [7:0] pos_code, [15:8] neg_code,
	                                           // [27:16] center_col, [39:28] center_row
	logic                  m_axis_tlast;       // frame_done
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Pixels waiting to be offered, and codes waiting to come out.
	logic [DEPTH_W-1:0] pixel_q [$];
	ltp_result_t        code_q [$];
	ltp_result_t        want_code;

	// Shadow of the block: line stores, window, raster position and registers.
	logic [DEPTH_W-1:0] upper_row [MAX_DIM];
	logic [DEPTH_W-1:0] middle_row [MAX_DIM];
	logic [DEPTH_W-1:0] win [3][3];
	int unsigned        col_pos = 0;
	int unsigned        row_pos = 0;
	logic [DIM_W-1:0]   width_reg = DIM_W'(WIDTH_RESET);
	logic [DIM_W-1:0]   height_reg = DIM_W'(HEIGHT_RESET);
	logic [THR_W-1:0]   thr_reg = THR_RESET;

	logic steady_flow = 1'b0;
	int   hold_requests = 0;
	int   holds_served = 0;
	int   hold_left = 0;
	int   quiet_cycles = 0;
	int   error_count = 0;
	int   pixels_sent = 0;
	int   codes_checked = 0;
	int   frames_seen = 0;
	int   settings_used = 0;

	local_ternary_pattern_3x3 #(
		.MAX_WIDTH(MAX_DIM),
		.MAX_HEIGHT(MAX_DIM)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 50 MHz clock.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// A geometry register is used within the legal range of 3 to the store size.
	function automatic int unsigned eff_dim(input logic [DIM_W-1:0] raw);
		if (raw < DIM_MIN)
			return DIM_MIN;
		if (raw > MAX_DIM)
			return MAX_DIM;
		return raw;
	endfunction

	// Shift one pixel into the shadow window and queue the codes it yields.
	function automatic void predict_codes(input logic [DEPTH_W-1:0] depth);
		int unsigned w_eff, h_eff, ctr, k;
		logic [7:0][DEPTH_W-1:0] nb;
		ltp_result_t res;
		w_eff = eff_dim(width_reg);
		h_eff = eff_dim(height_reg);
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = upper_row[col_pos];
		win[1][2] = middle_row[col_pos];
		win[2][2] = depth;
		upper_row[col_pos] = middle_row[col_pos];
		middle_row[col_pos] = depth;

		// Neighbors in code bit order: E, NE, N, NW, W, SW, S, SE.
		if (col_pos >= 2 && row_pos >= 2) begin
			nb = {win[2][2], win[2][1], win[2][0], win[1][0],
				win[0][0], win[0][1], win[0][2], win[1][2]};
			ctr = win[1][1];
			k = thr_reg;
			res = '0;
			for (int b = 0; b < 8; b++) begin
				if (nb[b] > ctr + k)
					res.pos_code[b] = 1'b1;
				if (nb[b] + k < ctr)
					res.neg_code[b] = 1'b1;
			end
			res.center_col = COORD_W'(col_pos - 1);
			res.center_row = COORD_W'(row_pos - 1);
			res.frame_done = (col_pos == w_eff - 1) && (row_pos == h_eff - 1);
			code_q.push_back(res);
		end

		// Advance the raster position, wrapping at the end of the frame.
		col_pos++;
		if (col_pos >= w_eff) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h_eff)
				row_pos = 0;
		end
	endfunction

	task automatic report_error(input string what, input int got, input int want);
		error_count++;
		if (error_count <= 30)
			$display("ERROR at code %0d: %s got %0d expected %0d",
				codes_checked, what, got, want);
	endtask

	// Register write, mirrored in the shadow registers. Only used while idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FRAME_WIDTH: begin
				width_reg = val[DIM_W-1:0];
				col_pos = 0;
				row_pos = 0;
			end
			REG_FRAME_HEIGHT: begin
				height_reg = val[DIM_W-1:0];
				col_pos = 0;
				row_pos = 0;
			end
			REG_THRESHOLD_K: thr_reg = val[THR_W-1:0];
			default: ;
		endcase
	endtask

	// Queue one 3x3 frame, given first pixel first.
	task automatic queue_frame(input logic [8:0][DEPTH_W-1:0] f);
		for (int i = 0; i < 9; i++)
			pixel_q.push_back(f[8-i]);
	endtask

	task automatic queue_pixels(input int count, input pix_mode_e mode);
		int base, lim, val;
		lim = 65535 - 2 * int'(thr_reg) - 1;
		base = (lim > 0) ? $urandom_range(lim) : 0;
		for (int i = 0; i < count; i++) begin
			case (mode)
				PIX_NOISE: val = $urandom_range(65535);
				// Steps of exactly k and k+1 land on both sides of each compare.
				PIX_NEAR_THRESHOLD:
					val = base + $urandom_range(2) * int'(thr_reg) + $urandom_range(1);
				PIX_EXTREME: begin
					case ($urandom_range(3))
						0: val = 0;
						1: val = 1;
						2: val = 65534;
						default: val = 65535;
					endcase
				end
				default: val = ($urandom_range(9) == 0) ? $urandom_range(65535) : base;
			endcase
			if (val > 65535)
				val = 65535;
			pixel_q.push_back(DEPTH_W'(val));
		end
	endtask

	// Wait until every pixel is taken and every code has come out, then let
	// the pipeline settle past any trailing border pixels.
	task automatic drain();
		while (pixel_q.size() != 0 || s_axis_tvalid || code_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Pixel driver: holds a beat until taken, idles now and then.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_codes(s_axis_tdata);
				pixels_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pixel_q.size() != 0 && (steady_flow || $urandom_range(99) >= 8)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= pixel_q.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Code monitor: checks each beat against the oldest expectation and
	// drives tready with random stalls and the occasional long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (m_axis_tlast)
					frames_seen++;
				if (code_q.size() == 0) begin
					report_error("code beat with nothing expected, center_col",
						m_axis_tdata[27:16], 0);
				end else begin
					want_code = code_q.pop_front();
					if (m_axis_tdata[7:0] != want_code.pos_code)
						report_error("pos_code", m_axis_tdata[7:0], want_code.pos_code);
					if (m_axis_tdata[15:8] != want_code.neg_code)
						report_error("neg_code", m_axis_tdata[15:8], want_code.neg_code);
					if (m_axis_tdata[27:16] != want_code.center_col)
						report_error("center_col", m_axis_tdata[27:16],
							want_code.center_col);
					if (m_axis_tdata[39:28] != want_code.center_row)
						report_error("center_row", m_axis_tdata[39:28],
							want_code.center_row);
					if (m_axis_tlast !== want_code.frame_done)
						report_error("frame_done", m_axis_tlast, want_code.frame_done);
				end
				codes_checked++;
			end
			if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= steady_flow || ($urandom_range(99) >= 8);
			end
		end
	end

	// Watchdog on cycles without any beat on either stream.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no beat for %0d cycles, %0d codes outstanding",
					quiet_cycles, code_q.size());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Stimulus sequence.
	initial begin
		int ph, w_val, h_val, w_eff, h_eff, n;
		pix_mode_e mode;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Smallest frame, with out-of-range geometry pulled up to 3x3.
		write_reg(REG_FRAME_WIDTH, 16'd0);
		write_reg(REG_FRAME_HEIGHT, 16'd2);
		write_reg(REG_THRESHOLD_K, 16'd0);
		settings_used++;
		// Bright center among darker and equal neighbors.
		queue_frame({16'd0, 16'd65535, 16'd1,
			16'd65534, 16'd65535, 16'd65535,
			16'd0, 16'd0, 16'd65535});
		// Dark center among brighter and equal neighbors.
		queue_frame({16'd65535, 16'd0, 16'd1,
			16'd1, 16'd0, 16'd65535,
			16'd0, 16'd65535, 16'd2});
		drain();

		// Largest threshold: even a full-scale step sets no bit.
		write_reg(REG_THRESHOLD_K, 16'hFFFF);
		settings_used++;
		queue_frame({16'd65535, 16'd65535, 16'd65535,
			16'd65535, 16'd0, 16'd65535,
			16'd65535, 16'd65535, 16'd65535});
		drain();

		// Random settings on small frames; some phases keep the geometry and
		// carry on mid-frame with only a new threshold.
		for (ph = 0; ph < 13; ph++) begin
			if (ph == 3)
				steady_flow <= 1'b1;
			if (ph == 5) begin
				steady_flow <= 1'b0;
				write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(65535)));
			end
			if (ph == 0 || $urandom_range(3) != 0) begin
				w_val = ($urandom_range(4) == 0) ? $urandom_range(2) : $urandom_range(3, 16);
				h_val = ($urandom_range(5) == 0) ? $urandom_range(2) : $urandom_range(3, 6);
				write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w_val));
				write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h_val));
			end
			case ($urandom_range(4))
				0: write_reg(REG_THRESHOLD_K, 16'd0);
				1: write_reg(REG_THRESHOLD_K, CFG_DATA_W'($urandom_range(1, 40)));
				2: write_reg(REG_THRESHOLD_K, CFG_DATA_W'($urandom_range(100, 2000)));
				3: write_reg(REG_THRESHOLD_K, CFG_DATA_W'($urandom_range(65535)));
				default: write_reg(REG_THRESHOLD_K, 16'hFFFF);
			endcase
			settings_used++;
			w_eff = eff_dim(width_reg);
			h_eff = eff_dim(height_reg);
			n = w_eff * h_eff + $urandom_range(w_eff * h_eff);
			mode = pix_mode_e'($urandom_range(3));
			if (ph == 6) begin
				// Keep offering while the output side holds off, so the block
				// fills up and stalls its input.
				queue_pixels(n + 120, mode);
				hold_requests <= hold_requests + 1;
			end else begin
				queue_pixels(n, mode);
			end
			drain();
		end

		// Width register overflows and is capped to the store size; the start
		// of the first row yields no codes.
		write_reg(REG_FRAME_WIDTH, 16'hFFFF);
		write_reg(REG_FRAME_HEIGHT, 16'd3);
		write_reg(REG_THRESHOLD_K, CFG_DATA_W'($urandom_range(65535)));
		settings_used++;
		queue_pixels(WIDE_PIXELS, PIX_NOISE);
		drain();

		// Narrow, tall frame; the height register overflows and is capped.
		write_reg(REG_FRAME_WIDTH, 16'd1);
		write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
		write_reg(REG_THRESHOLD_K, CFG_DATA_W'($urandom_range(1, 40)));
		settings_used++;
		queue_pixels(DIM_MIN * TALL_ROWS, PIX_NEAR_THRESHOLD);
		drain();

		$display("Sent %0d pixels under %0d register settings, small frames and capped geometry",
			pixels_sent, settings_used);
		$display("Compared %0d code beats, %0d of them frame ends",
			codes_checked, frames_seen);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
